// ===== rtl/core/bfa_pkg.sv =====
// Best-fit block allocator: shared types, constants and the microcode ROM.
// No dependencies; used by best_fit_block_allocator_core and its testbench.
`default_nettype none

package bfa_pkg;

   localparam int HEAP_UNITS = 512;
   localparam int IDX_W      = $clog2(HEAP_UNITS);
   localparam int HDR_W      = 13;
   localparam int SZ_W       = HDR_W - 3;              // size field in 8-byte units
   localparam int CUR_W      = ((IDX_W > SZ_W) ? IDX_W : SZ_W) + 1;
   localparam int REQ_W      = 12;
   localparam int OFF_W      = 12;

   localparam logic [HDR_W-1:0] END_MARK = HDR_W'(1);

   typedef enum logic [3:0] {
      S_INIT0,
      S_INIT1,
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_DECIDE,
      S_FIXNXT,
      S_SETHDR,
      S_FINISH
   } step_type;

   typedef enum logic [1:0] {
      WSEL_INIT0,
      WSEL_END,
      WSEL_NXT,
      WSEL_BEST
   } wsel_type;

   typedef enum logic [1:0] {
      RSEL_ZERO,
      RSEL_WALK,
      RSEL_NXT
   } rsel_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_ZERO,
      C_WALK_DONE,
      C_FOUND,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     accept_en;
      logic     clr_best;
      logic     walk_en;
      logic     post_en;
      logic     mem_we;
      wsel_type wsel;
      rsel_type rsel;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
   } ctl_type;

   // Microcode ROM: one control word per step.
   function automatic ctl_type ucode(input step_type step);
      ctl_type c;
      c = '{accept_en: 1'b0, clr_best: 1'b0, walk_en: 1'b0, post_en: 1'b0,
            mem_we: 1'b0, wsel: WSEL_BEST, rsel: RSEL_ZERO, cond: C_ALWAYS,
            tgt_t: S_IDLE, tgt_f: S_IDLE};
      case (step)
         S_INIT0: begin
            c.mem_we = 1'b1;
            c.wsel   = WSEL_INIT0;
            c.tgt_t  = S_INIT1;
         end
         S_INIT1: begin
            c.mem_we = 1'b1;
            c.wsel   = WSEL_END;
            c.tgt_t  = S_IDLE;
         end
         S_IDLE: begin
            c.accept_en = 1'b1;
            c.cond      = C_ACCEPT;
            c.tgt_t     = S_CHECK;
            c.tgt_f     = S_IDLE;
         end
         S_CHECK: begin
            c.clr_best = 1'b1;
            c.rsel     = RSEL_ZERO;
            c.cond     = C_ZERO;
            c.tgt_t    = S_FINISH;
            c.tgt_f    = S_WALK;
         end
         S_WALK: begin
            c.walk_en = 1'b1;
            c.rsel    = RSEL_WALK;
            c.cond    = C_WALK_DONE;
            c.tgt_t   = S_DECIDE;
            c.tgt_f   = S_WALK;
         end
         S_DECIDE: begin
            c.rsel  = RSEL_NXT;
            c.cond  = C_FOUND;
            c.tgt_t = S_FIXNXT;
            c.tgt_f = S_FINISH;
         end
         S_FIXNXT: begin
            c.mem_we = 1'b1;
            c.wsel   = WSEL_NXT;
            c.tgt_t  = S_SETHDR;
         end
         S_SETHDR: begin
            c.mem_we = 1'b1;
            c.wsel   = WSEL_BEST;
            c.tgt_t  = S_FINISH;
         end
         S_FINISH: begin
            c.post_en = 1'b1;
            c.cond    = C_OUT_FREE;
            c.tgt_t   = S_IDLE;
            c.tgt_f   = S_FINISH;
         end
         default: begin
            c.tgt_t = S_INIT0;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/best_fit_block_allocator_core.sv =====
//  channel | ports                               | dir | beat moves on
//  req     | req_valid req_stall req_request_bytes | in  | valid & !stall
//  rsp     | rsp_valid rsp_stall rsp_granted       | out | valid & !stall
//          |   rsp_payload_offset                  |     |
//
// The walk reads one header per cycle, end mark included, up to HEAP_UNITS headers.
// A granted request goes through check, walk, decide, fix-next, set-header and finish;
// a refused one goes from decide to finish, and a zero request from check to finish.
// After reset the steps S_INIT0 and S_INIT1 write the first free block and the end mark;
// no beat is taken meanwhile. Requests are taken one at a time; a result that finds
// the result register stalled holds the sequencer in its last step until it frees.
// Best-fit allocator core: microcoded sequencer over a header RAM.
// Depends on bfa_pkg and bfa_ram.
`default_nettype none

module best_fit_block_allocator_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [bfa_pkg::REQ_W-1:0] req_request_bytes,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_granted,
   output logic      [bfa_pkg::OFF_W-1:0] rsp_payload_offset
);

   localparam int IDX_W = bfa_pkg::IDX_W;
   localparam int SZ_W  = bfa_pkg::SZ_W;
   localparam int CUR_W = bfa_pkg::CUR_W;
   localparam int HDR_W = bfa_pkg::HDR_W;
   localparam int OFF_W = bfa_pkg::OFF_W;
   localparam int REQ_W = bfa_pkg::REQ_W;
   localparam logic [CUR_W-1:0] HEAP_LIM = CUR_W'(bfa_pkg::HEAP_UNITS);
   localparam logic [SZ_W-1:0]  INIT_UNITS = SZ_W'(bfa_pkg::HEAP_UNITS - 1);

   bfa_pkg::step_type step_ff, step_in;
   bfa_pkg::ctl_type  ctl;

   logic [SZ_W-1:0]  need_ff, need_in;
   logic             zero_ff, zero_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             found_ff, found_in;
   logic [SZ_W-1:0]  best_units_ff, best_units_in;
   logic [IDX_W-1:0] best_unit_ff, best_unit_in;
   logic             best_prev_ff, best_prev_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_granted_ff, rsp_granted_in;
   logic [OFF_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [HDR_W-1:0] mem_wdata, hdr;

   logic             req_beat, out_free;
   logic [REQ_W:0]   need_sum;
   logic [SZ_W-1:0]  sz_units;
   logic             brk, walk_done, take;
   logic [CUR_W-1:0] next_cur, nxt;
   logic             nxt_ok, split;
   logic [IDX_W+OFF_W+2:0] off_full;

   assign ctl       = bfa_pkg::ucode(step_ff);
   assign req_stall = !ctl.accept_en;
   assign req_beat  = req_valid && ctl.accept_en;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // needed block in 8-byte units: (req + 4 + 7) / 8
   assign need_sum = {1'b0, req_request_bytes} + (REQ_W + 1)'(11);

   // walk datapath
   assign sz_units  = hdr[HDR_W-1:3];
   assign brk       = (hdr == bfa_pkg::END_MARK) || (sz_units == '0);
   assign next_cur  = CUR_W'(cur_ff) + CUR_W'(sz_units);
   assign walk_done = brk || (next_cur >= HEAP_LIM);
   assign take      = !brk && !hdr[0] && (sz_units >= need_ff)
                      && (!found_ff || (sz_units < best_units_ff));

   // allocation datapath
   assign nxt    = CUR_W'(best_unit_ff) + CUR_W'(need_ff);
   assign nxt_ok = nxt < HEAP_LIM;
   assign split  = best_units_ff > need_ff;

   assign off_full = {{OFF_W{1'b0}}, best_unit_ff, 3'b100};

   always_comb begin
      mem_raddr = '0;
      case (ctl.rsel)
         bfa_pkg::RSEL_ZERO: mem_raddr = '0;
         bfa_pkg::RSEL_WALK: mem_raddr = next_cur[IDX_W-1:0];
         bfa_pkg::RSEL_NXT:  mem_raddr = nxt[IDX_W-1:0];
         default:            mem_raddr = '0;
      endcase
   end

   always_comb begin
      mem_we    = ctl.mem_we;
      mem_waddr = best_unit_ff;
      mem_wdata = {need_ff, 1'b0, best_prev_ff, 1'b1};
      case (ctl.wsel)
         bfa_pkg::WSEL_INIT0: begin
            mem_waddr = '0;
            mem_wdata = {INIT_UNITS, 3'b010};
         end
         bfa_pkg::WSEL_END: begin
            mem_waddr = IDX_W'(bfa_pkg::HEAP_UNITS - 1);
            mem_wdata = bfa_pkg::END_MARK;
         end
         bfa_pkg::WSEL_NXT: begin
            // split remainder, or flag the following block as having a taken neighbor
            mem_waddr = nxt[IDX_W-1:0];
            mem_we    = ctl.mem_we && nxt_ok && (split || (hdr != bfa_pkg::END_MARK));
            mem_wdata = split ? {best_units_ff - need_ff, 3'b010}
                              : {hdr[HDR_W-1:3], 1'b0, 1'b1, hdr[0]};
         end
         bfa_pkg::WSEL_BEST: begin
            mem_waddr = best_unit_ff;
            mem_wdata = {need_ff, 1'b0, best_prev_ff, 1'b1};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   bfa_ram #(
      .WIDTH (HDR_W),
      .DEPTH (bfa_pkg::HEAP_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (hdr)
   );

   // sequencer: next step from the control word's condition
   always_comb begin
      logic c;
      c = 1'b1;
      case (ctl.cond)
         bfa_pkg::C_ALWAYS:    c = 1'b1;
         bfa_pkg::C_ACCEPT:    c = req_beat;
         bfa_pkg::C_ZERO:      c = zero_ff;
         bfa_pkg::C_WALK_DONE: c = walk_done;
         bfa_pkg::C_FOUND:     c = found_ff;
         bfa_pkg::C_OUT_FREE:  c = out_free;
         default:              c = 1'b1;
      endcase
      step_in = c ? ctl.tgt_t : ctl.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bfa_pkg::S_INIT0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      need_in       = need_ff;
      zero_in       = zero_ff;
      cur_in        = cur_ff;
      found_in      = found_ff;
      best_units_in = best_units_ff;
      best_unit_in  = best_unit_ff;
      best_prev_in  = best_prev_ff;
      if (req_beat) begin
         need_in = need_sum[REQ_W:3];
         zero_in = req_request_bytes == '0;
      end
      if (ctl.clr_best) begin
         cur_in   = '0;
         found_in = 1'b0;
      end
      if (ctl.walk_en) begin
         cur_in = next_cur[IDX_W-1:0];
         if (take) begin
            found_in      = 1'b1;
            best_units_in = sz_units;
            best_unit_in  = cur_ff;
            best_prev_in  = hdr[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      need_ff       <= need_in;
      zero_ff       <= zero_in;
      cur_ff        <= cur_in;
      best_units_ff <= best_units_in;
      best_unit_ff  <= best_unit_in;
      best_prev_ff  <= best_prev_in;
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_offset_in  = rsp_offset_ff;
      if (ctl.post_en && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = found_ff;
         rsp_offset_in  = found_ff ? off_full[OFF_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_granted_ff <= rsp_granted_in;
      rsp_offset_ff  <= rsp_offset_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_payload_offset = rsp_offset_ff;

   a_reset_init: assert property (@(posedge clock)
      reset |=> step_ff == bfa_pkg::S_INIT0)
      else $error("sequencer did not restart at init");

   a_grant_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted_ff |-> rsp_offset_ff[2:0] == 3'b100)
      else $error("granted offset not on a payload boundary");

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> rsp_offset_ff == '0)
      else $error("refused beat carries an offset");

   // the check step still sees the previous request's choice
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff && !ctl.accept_en && !ctl.clr_best |-> best_units_ff >= need_ff)
      else $error("chosen block smaller than needed");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !ctl.accept_en && !ctl.walk_en)
      else $error("header write while idle or walking");

endmodule

`default_nettype wire

// ===== sim/best_fit_block_allocator_core_tb.sv =====
// Self-checking testbench for best_fit_block_allocator_core: directed table, some rows with
// fixed expectations, then random requests; the rest checked against a bench best-fit heap model.
// Depends on bfa_pkg and the core RTL (with bfa_ram).
`timescale 1ns / 100ps

module best_fit_block_allocator_core_tb;

   localparam int HEAP_UNITS = bfa_pkg::HEAP_UNITS;
   localparam int HDR_W      = bfa_pkg::HDR_W;
   localparam int REQ_W      = bfa_pkg::REQ_W;
   localparam int OFF_W      = bfa_pkg::OFF_W;
   localparam logic [HDR_W-1:0] END_MARK = bfa_pkg::END_MARK;

   localparam int UNIT_BYTES = 8;
   localparam int HDR_BYTES  = 4;
   localparam int NO_FIT     = 32'h7fff_ffff;
   localparam int N_DIR      = 17;
   localparam int N_RAND     = 735;
   localparam int WATCHDOG   = 3000;
   localparam int DRAIN      = 600;

   typedef struct packed {
      logic             granted;
      logic [OFF_W-1:0] offset;
   } grant_type;

   typedef struct packed {
      logic [REQ_W-1:0] bytes;
      logic             typed;
      logic             granted;
      logic [OFF_W-1:0] offset;
   } dir_row_type;

   // fixed expectations only where they follow from a fresh heap
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{12'd0,    1'b1, 1'b0, 12'd0},   // zero request
      '{12'd4095, 1'b1, 1'b0, 12'd0},   // largest request, never fits
      '{12'd4085, 1'b1, 1'b0, 12'd0},   // rounds up to the whole heap, one unit past the free block
      '{12'd1,    1'b1, 1'b1, 12'd4},   // smallest block, unit 0
      '{12'd4,    1'b1, 1'b1, 12'd12},
      '{12'd5,    1'b1, 1'b1, 12'd20},  // rounds 9 up to 16
      '{12'd12,   1'b1, 1'b1, 12'd36},
      '{12'd13,   1'b1, 1'b1, 12'd52},
      '{12'd600,  1'b0, 1'b0, 12'd0},
      '{12'd1,    1'b0, 1'b0, 12'd0},
      '{12'd0,    1'b1, 1'b0, 12'd0},
      '{12'd4095, 1'b1, 1'b0, 12'd0},
      '{12'd200,  1'b0, 1'b0, 12'd0},
      '{12'd255,  1'b0, 1'b0, 12'd0},
      '{12'd4084, 1'b0, 1'b0, 12'd0},   // fit on a fresh heap, too big now
      '{12'd2,    1'b0, 1'b0, 12'd0},
      '{12'd96,   1'b0, 1'b0, 12'd0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [REQ_W-1:0] req_request_bytes = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_granted;
   logic [OFF_W-1:0] rsp_payload_offset;

   logic [HDR_W-1:0] heap_hdr [HEAP_UNITS];
   grant_type        pending_grants [$];
   int               mismatch_count = 0;
   int               beat_count = 0;
   int               stall_left = 0;
   bit               quiet_sink = 1'b0;
   int               idle_cycles = 0;
   grant_type        want;

   best_fit_block_allocator_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_request_bytes  (req_request_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted        (rsp_granted),
      .rsp_payload_offset (rsp_payload_offset)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // heap after reset: one free block up to the end mark
   initial begin
      for (int u = 0; u < HEAP_UNITS; u++) heap_hdr[u] = '0;
      heap_hdr[0] = HDR_W'((HEAP_UNITS - 1) * UNIT_BYTES) | HDR_W'(2);
      heap_hdr[HEAP_UNITS-1] = END_MARK;
   end

   // Walk every header, take the smallest free block that fits (first on a tie),
   // split off the remainder or flag the next block on an exact fit.
   task automatic allocate_best_fit(input logic [REQ_W-1:0] bytes, output grant_type res);
      int               need, pos, blk_bytes, best_bytes, best_pos, nxt;
      logic             best_prev, found, walking;
      logic [HDR_W-1:0] hdr;
      res = '0;
      found = 1'b0;
      if (bytes != 0) begin
         need = (int'(bytes) + HDR_BYTES + UNIT_BYTES - 1) & ~(UNIT_BYTES - 1);
         best_bytes = NO_FIT;
         best_pos = 0;
         best_prev = 1'b0;
         pos = 0;
         walking = 1'b1;
         while (walking && pos < HEAP_UNITS) begin
            hdr = heap_hdr[pos];
            blk_bytes = int'({hdr[HDR_W-1:3], 3'b000});
            if (hdr == END_MARK || blk_bytes == 0) begin
               walking = 1'b0;   // end mark or broken chain
            end else begin
               if (!hdr[0] && blk_bytes >= need && blk_bytes < best_bytes) begin
                  best_bytes = blk_bytes;
                  best_pos = pos;
                  best_prev = hdr[1];
                  found = 1'b1;
               end
               pos += blk_bytes / UNIT_BYTES;
            end
         end
      end
      if (found) begin
         nxt = best_pos + need / UNIT_BYTES;
         if (nxt < HEAP_UNITS) begin
            hdr = heap_hdr[nxt];
            if (best_bytes > need)
               heap_hdr[nxt] = HDR_W'(best_bytes - need) | HDR_W'(2);
            else if (hdr != END_MARK)
               heap_hdr[nxt] = {hdr[HDR_W-1:3], 1'b0, 1'b1, hdr[0]};
         end
         heap_hdr[best_pos] = HDR_W'(need) | {best_prev, 1'b1};
         res.granted = 1'b1;
         res.offset = OFF_W'(best_pos * UNIT_BYTES + HDR_BYTES);
      end
   endtask

   initial begin : drive_requests
      int               gap, pick, room, pos, blk;
      bit               quiet_src;
      logic [REQ_W-1:0] bytes;
      grant_type        res;
      quiet_src = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < N_DIR + N_RAND; i++) begin
         if (i < N_DIR) begin
            bytes = DIR_ROWS[i].bytes;
         end else begin
            // largest free block left, to aim an exact fit when the heap is nearly full
            room = 0;
            pos = 0;
            while (pos < HEAP_UNITS && heap_hdr[pos] != END_MARK
                   && heap_hdr[pos][HDR_W-1:3] != 0) begin
               blk = int'(heap_hdr[pos][HDR_W-1:3]) * UNIT_BYTES;
               if (!heap_hdr[pos][0] && blk > room) room = blk;
               pos += blk / UNIT_BYTES;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
               bytes = '0;
            else if (pick < 6 && i >= N_DIR + 350)
               bytes = REQ_W'($urandom_range(0, 4095));
            else if (pick < 9 && room >= UNIT_BYTES && room <= 128)
               bytes = REQ_W'(room - HDR_BYTES - $urandom_range(0, 3));
            else if (pick < 20)
               bytes = REQ_W'($urandom_range(13, 96));
            else
               bytes = REQ_W'($urandom_range(1, 12));
         end
         if (i % 40 == 0) quiet_src = ($urandom_range(0, 3) == 0);
         gap = quiet_src ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_request_bytes <= bytes;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         allocate_best_fit(bytes, res);
         if (i < N_DIR && DIR_ROWS[i].typed)
            pending_grants.push_back({DIR_ROWS[i].granted, DIR_ROWS[i].offset});
         else
            pending_grants.push_back(res);
      end
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0 && pending_grants.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result side: check each beat, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat %0d: unexpected result granted %0d offset %0d",
                           beat_count, rsp_granted, rsp_payload_offset);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted !== want.granted || rsp_payload_offset !== want.offset) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("beat %0d: granted exp %0d got %0d, offset exp %0d got %0d",
                              beat_count, want.granted, rsp_granted,
                              want.offset, rsp_payload_offset);
               end
            end
            beat_count++;
            if (beat_count % 40 == 0) quiet_sink = ($urandom_range(0, 3) == 0);
            stall_left = quiet_sink ? 0 : $urandom_range(0, 16);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
